/* design/jsu_pkg.sv */
// Shared types, codes and UTF-8 helpers for the JSON string unescaper.
package jsu_pkg;

    localparam int JSU_QUEUE_DEPTH = 4;
    localparam int JSU_MAX_RESULTS = 4;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] ERR_NO_QUOTE     = 4'd0;
    localparam logic [3:0] ERR_CONTROL      = 4'd1;
    localparam logic [3:0] ERR_TRUNC_ESC    = 4'd2;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
    localparam logic [3:0] ERR_MISSING_LOW  = 4'd4;
    localparam logic [3:0] ERR_BAD_LOW      = 4'd5;
    localparam logic [3:0] ERR_LONE_LOW     = 4'd6;
    localparam logic [3:0] ERR_BAD_ESC      = 4'd7;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd8;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic [3:0] error_code;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic [3:0] error_code;
    } t_res;

    typedef struct packed {
        logic [2:0]                       count;
        t_res [JSU_MAX_RESULTS-1:0]       res;
    } t_group;

    function automatic t_res f_res(logic [1:0] kind, logic [7:0] b, logic [3:0] code);
        t_res r;
        r.result_kind = kind;
        r.out_byte    = (kind == KIND_BYTE) ? b : 8'd0;
        r.error_code  = (kind == KIND_ERROR) ? code : 4'd0;
        return r;
    endfunction

    function automatic t_group f_empty();
        t_group g;
        g.count = 3'd0;
        for (int k = 0; k < JSU_MAX_RESULTS; k++) begin
            g.res[k] = f_res(KIND_BYTE, 8'd0, 4'd0);
        end
        return g;
    endfunction

    function automatic t_group f_single(logic [1:0] kind, logic [7:0] b, logic [3:0] code);
        t_group g;
        g        = f_empty();
        g.count  = 3'd1;
        g.res[0] = f_res(kind, b, code);
        return g;
    endfunction

    function automatic t_group f_utf8(logic [20:0] cp);
        t_group g;
        g = f_empty();
        if (cp <= 21'h7f) begin
            g.count  = 3'd1;
            g.res[0] = f_res(KIND_BYTE, cp[7:0], 4'd0);
        end else if (cp <= 21'h7ff) begin
            g.count  = 3'd2;
            g.res[0] = f_res(KIND_BYTE, {3'b110, cp[10:6]}, 4'd0);
            g.res[1] = f_res(KIND_BYTE, {2'b10, cp[5:0]}, 4'd0);
        end else if (cp <= 21'hffff) begin
            g.count  = 3'd3;
            g.res[0] = f_res(KIND_BYTE, {4'b1110, cp[15:12]}, 4'd0);
            g.res[1] = f_res(KIND_BYTE, {2'b10, cp[11:6]}, 4'd0);
            g.res[2] = f_res(KIND_BYTE, {2'b10, cp[5:0]}, 4'd0);
        end else begin
            g.count  = 3'd4;
            g.res[0] = f_res(KIND_BYTE, {5'b11110, cp[20:18]}, 4'd0);
            g.res[1] = f_res(KIND_BYTE, {2'b10, cp[17:12]}, 4'd0);
            g.res[2] = f_res(KIND_BYTE, {2'b10, cp[11:6]}, 4'd0);
            g.res[3] = f_res(KIND_BYTE, {2'b10, cp[5:0]}, 4'd0);
        end
        return g;
    endfunction

    // bit 4 set marks a byte that is not a hex digit
    function automatic logic [4:0] f_hex(logic [7:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d = {1'b0, c[3:0] + 4'd9};
        end else begin
            d = 5'h10;
        end
        return d;
    endfunction

endpackage

/* design/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper producing UTF-8.
//
// Input channel: one raw byte of a JSON string literal per transaction, starting
// with its opening quote; end_of_text marks the end of input and carries no byte.
// Output channel: one result per transaction - a decoded UTF-8 byte, the close
// of the string, or an error with its code; last_of_run flags the final result
// caused by one input byte. Bytes that cause no result produce nothing.
// Throughput: one input byte per cycle, and one result per cycle while the output
// is not stalled. A \u escape can give up to four results from one byte; the group
// queue absorbs such bursts and input stalls only when the queue of QUEUE_DEPTH
// groups is full. When the output side is free, a result passes the queue write,
// the serializer load and the output register in turn after its byte is accepted.
// Reset: returns to idle awaiting an opening quote, empties the queue and drops
// any pending output. A stalled output holds its transaction unchanged, and
// once the queue fills the input stall rises.
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jsu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jsu_pkg::t_out_item o_out_item
);
    import jsu_pkg::*;

    logic   push, pop, full, nonempty;
    t_group group, head;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_group (group)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_group    (group),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out_item)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("group pushed into full queue");
    a_pop_only_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> nonempty)
        else $error("pop from empty queue");
    a_push_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (group.count != 3'd0))
        else $error("empty group pushed");

endmodule

/* design/jsu_front.sv */
// Front end: accepts raw bytes, tracks the escape state and builds result groups.
module jsu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  jsu_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output jsu_pkg::t_group   o_group
);
    import jsu_pkg::*;

    t_phase      r_phase, n_phase;
    logic [11:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_hs, n_hs;
    t_group      n_group;
    logic        accept;
    logic [4:0]  hex;
    logic [15:0] v;
    logic [7:0]  c;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign c       = i_item.in_byte;
    assign hex     = f_hex(c);
    assign v       = {r_acc, hex[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_hs    <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_hs    <= n_hs;
        end
    end

    always_comb begin
        logic fail;
        logic [3:0] code;
        fail    = 1'b0;
        code    = ERR_NO_QUOTE;
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_hs    = r_hs;
        n_group = f_empty();
        if (i_item.end_of_text) begin
            fail = 1'b1;
            unique case (r_phase) inside
                PH_BODY:                        code = ERR_UNTERMINATED;
                PH_ESC:                         code = ERR_TRUNC_ESC;
                PH_HEX1:                        code = ERR_BAD_HEX;
                PH_WANT_BS, PH_WANT_U, PH_HEX2: code = ERR_MISSING_LOW;
                default:                        code = ERR_NO_QUOTE;
            endcase
        end else begin
            unique case (r_phase) inside
                PH_BODY: begin
                    if (c == CH_QUOTE) begin
                        n_group = f_single(KIND_CLOSE, 8'd0, 4'd0);
                        n_phase = PH_IDLE;
                    end else if (c < 8'h20) begin
                        fail = 1'b1;
                        code = ERR_CONTROL;
                    end else if (c == CH_BACKSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        n_group = f_single(KIND_BYTE, c, 4'd0);
                    end
                end
                PH_ESC: begin
                    n_phase = PH_BODY;
                    unique case (c) inside
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: n_group = f_single(KIND_BYTE, c, 4'd0);
                        8'h62: n_group = f_single(KIND_BYTE, 8'h08, 4'd0);
                        8'h66: n_group = f_single(KIND_BYTE, 8'h0c, 4'd0);
                        8'h6e: n_group = f_single(KIND_BYTE, 8'h0a, 4'd0);
                        8'h72: n_group = f_single(KIND_BYTE, 8'h0d, 4'd0);
                        8'h74: n_group = f_single(KIND_BYTE, 8'h09, 4'd0);
                        CH_U: begin
                            n_phase = PH_HEX1;
                            n_acc   = '0;
                            n_cnt   = '0;
                        end
                        default: begin
                            fail = 1'b1;
                            code = ERR_BAD_ESC;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2: begin
                    if (hex[4]) begin
                        fail = 1'b1;
                        code = (r_phase == PH_HEX1) ? ERR_BAD_HEX : ERR_BAD_LOW;
                    end else if (r_cnt != 2'd3) begin
                        n_acc = {r_acc[7:0], hex[3:0]};
                        n_cnt = r_cnt + 2'd1;
                    end else begin
                        n_cnt = '0;
                        n_acc = v[11:0];
                        if (r_phase == PH_HEX1) begin
                            if (v[15:10] == SURR_HIGH_TAG) begin
                                n_hs    = v[9:0];
                                n_phase = PH_WANT_BS;
                            end else if (v[15:10] == SURR_LOW_TAG) begin
                                fail = 1'b1;
                                code = ERR_LONE_LOW;
                            end else begin
                                n_group = f_utf8({5'd0, v});
                                n_phase = PH_BODY;
                            end
                        end else begin
                            if (v[15:10] != SURR_LOW_TAG) begin
                                fail = 1'b1;
                                code = ERR_BAD_LOW;
                            end else begin
                                n_group = f_utf8({{1'b0, r_hs} + 11'd64, v[9:0]});
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
                PH_WANT_BS: begin
                    if (c == CH_BACKSLASH) begin
                        n_phase = PH_WANT_U;
                    end else begin
                        fail = 1'b1;
                        code = ERR_MISSING_LOW;
                    end
                end
                PH_WANT_U: begin
                    if (c == CH_U) begin
                        n_phase = PH_HEX2;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end else begin
                        fail = 1'b1;
                        code = ERR_MISSING_LOW;
                    end
                end
                default: begin
                    if (c == CH_QUOTE) begin
                        n_phase = PH_BODY;
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_hs    = '0;
                    end else begin
                        fail = 1'b1;
                        code = ERR_NO_QUOTE;
                    end
                end
            endcase
        end
        if (fail) begin
            n_group = f_single(KIND_ERROR, 8'd0, code);
            n_phase = PH_IDLE;
            n_acc   = '0;
            n_cnt   = '0;
            n_hs    = '0;
        end
    end

    assign o_push  = accept && (n_group.count != 3'd0);
    assign o_group = n_group;

endmodule

/* design/jsu_queue.sv */
// Short group queue between the front end and the result serializer.
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jsu_pkg::t_group i_group,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output jsu_pkg::t_group o_head
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group        r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!do_push && do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

endmodule

/* design/jsu_back.sv */
// Back end: serializes queued result groups onto the registered output channel.
module jsu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_nonempty,
    input  jsu_pkg::t_group    i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output jsu_pkg::t_out_item o_item
);
    import jsu_pkg::*;

    logic      r_busy;
    t_group    r_grp;
    logic [1:0] r_idx;
    logic      r_valid;
    t_out_item r_item;
    logic      free, emit, last;

    assign free  = !r_valid || !i_stall;
    assign emit  = r_busy && free;
    assign last  = (({1'b0, r_idx} + 3'd1) == r_grp.count);
    assign o_pop = i_nonempty && (!r_busy || (emit && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
            end else if (free) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_head;
        end
        if (emit) begin
            r_item.out_byte    <= r_grp.res[r_idx].out_byte;
            r_item.result_kind <= r_grp.res[r_idx].result_kind;
            r_item.error_code  <= r_grp.res[r_idx].error_code;
            r_item.last_of_run <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_busy_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_grp.count != 3'd0 && r_grp.count <= 3'd4))
        else $error("active group has no results");
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.result_kind != KIND_BYTE) |-> r_item.last_of_run)
        else $error("close or error result not last of run");
    a_emit_drops_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last && !o_pop) |=> !r_busy)
        else $error("serializer stayed busy after last result");

endmodule

/* bench/jsu_checker.sv */
// Checker for the JSON string unescaper: predicts each result from the input stream and compares.
module jsu_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  jsu_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  jsu_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_bytes_in,
    output int                 o_results,
    output bit [8:0]           o_err_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int MAX_REPORTS = 20;

    t_phase      phase_q = PH_IDLE;
    logic [15:0] hex_acc = '0;
    logic [1:0]  digit_cnt = '0;
    logic [9:0]  high_half = '0;
    t_out_item   decoded_q[$];
    t_out_item   step_q[$];
    int          fails = 0;
    int          n_in = 0;
    int          n_out = 0;
    bit [8:0]    err_mask = '0;

    function automatic int nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic clear_state();
        phase_q   = PH_IDLE;
        hex_acc   = '0;
        digit_cnt = '0;
        high_half = '0;
    endtask

    task automatic emit(logic [1:0] kind, logic [7:0] b, logic [3:0] code);
        t_out_item r;
        r.out_byte    = (kind == KIND_BYTE) ? b : 8'd0;
        r.result_kind = kind;
        r.error_code  = (kind == KIND_ERROR) ? code : 4'd0;
        r.last_of_run = 1'b0;
        step_q.push_back(r);
    endtask

    task automatic abort_string(logic [3:0] code);
        emit(KIND_ERROR, '0, code);
        clear_state();
    endtask

    task automatic put_code_point(logic [20:0] cp);
        if (cp <= 21'h7f) begin
            emit(KIND_BYTE, cp[7:0], '0);
        end else if (cp <= 21'h7ff) begin
            emit(KIND_BYTE, 8'hc0 | 8'(cp >> 6), '0);
            emit(KIND_BYTE, 8'h80 | 8'(cp[5:0]), '0);
        end else if (cp <= 21'hffff) begin
            emit(KIND_BYTE, 8'he0 | 8'(cp >> 12), '0);
            emit(KIND_BYTE, 8'h80 | 8'(cp[11:6]), '0);
            emit(KIND_BYTE, 8'h80 | 8'(cp[5:0]), '0);
        end else begin
            emit(KIND_BYTE, 8'hf0 | 8'(cp[20:18]), '0);
            emit(KIND_BYTE, 8'h80 | 8'(cp[17:12]), '0);
            emit(KIND_BYTE, 8'h80 | 8'(cp[11:6]), '0);
            emit(KIND_BYTE, 8'h80 | 8'(cp[5:0]), '0);
        end
    endtask

    task automatic decode_byte(t_in_item it);
        logic [7:0]  c;
        logic [15:0] v;
        int          d;
        c = it.in_byte;
        step_q.delete();
        if (it.end_of_text) begin
            case (phase_q) inside
                PH_BODY:                        abort_string(ERR_UNTERMINATED);
                PH_ESC:                         abort_string(ERR_TRUNC_ESC);
                PH_HEX1:                        abort_string(ERR_BAD_HEX);
                PH_WANT_BS, PH_WANT_U, PH_HEX2: abort_string(ERR_MISSING_LOW);
                default:                        abort_string(ERR_NO_QUOTE);
            endcase
        end else begin
            case (phase_q) inside
                PH_BODY: begin
                    if (c == CH_QUOTE) begin
                        emit(KIND_CLOSE, '0, '0);
                        phase_q = PH_IDLE;
                    end else if (c < 8'h20) begin
                        abort_string(ERR_CONTROL);
                    end else if (c == CH_BACKSLASH) begin
                        phase_q = PH_ESC;
                    end else begin
                        emit(KIND_BYTE, c, '0);
                    end
                end
                PH_ESC: begin
                    phase_q = PH_BODY;
                    case (c) inside
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: emit(KIND_BYTE, c, '0);
                        "b": emit(KIND_BYTE, 8'h08, '0);
                        "f": emit(KIND_BYTE, 8'h0c, '0);
                        "n": emit(KIND_BYTE, 8'h0a, '0);
                        "r": emit(KIND_BYTE, 8'h0d, '0);
                        "t": emit(KIND_BYTE, 8'h09, '0);
                        CH_U: begin
                            phase_q   = PH_HEX1;
                            hex_acc   = '0;
                            digit_cnt = '0;
                        end
                        default: abort_string(ERR_BAD_ESC);
                    endcase
                end
                PH_HEX1, PH_HEX2: begin
                    d = nibble_of(c);
                    if (d < 0) begin
                        abort_string(phase_q == PH_HEX1 ? ERR_BAD_HEX : ERR_BAD_LOW);
                    end else begin
                        hex_acc = {hex_acc[11:0], d[3:0]};
                        if (digit_cnt != 2'd3) begin
                            digit_cnt = digit_cnt + 2'd1;
                        end else begin
                            digit_cnt = '0;
                            v = hex_acc;
                            if (phase_q == PH_HEX1) begin
                                if (v >= 16'hd800 && v <= 16'hdbff) begin
                                    high_half = v[9:0];
                                    phase_q   = PH_WANT_BS;
                                end else if (v >= 16'hdc00 && v <= 16'hdfff) begin
                                    abort_string(ERR_LONE_LOW);
                                end else begin
                                    put_code_point({5'd0, v});
                                    phase_q = PH_BODY;
                                end
                            end else if (v >= 16'hdc00 && v <= 16'hdfff) begin
                                put_code_point(21'h10000 + {high_half, v[9:0]});
                                phase_q = PH_BODY;
                            end else begin
                                abort_string(ERR_BAD_LOW);
                            end
                        end
                    end
                end
                PH_WANT_BS: begin
                    if (c == CH_BACKSLASH) begin
                        phase_q = PH_WANT_U;
                    end else begin
                        abort_string(ERR_MISSING_LOW);
                    end
                end
                PH_WANT_U: begin
                    if (c == CH_U) begin
                        phase_q   = PH_HEX2;
                        hex_acc   = '0;
                        digit_cnt = '0;
                    end else begin
                        abort_string(ERR_MISSING_LOW);
                    end
                end
                default: begin
                    if (c == CH_QUOTE) begin
                        clear_state();
                        phase_q = PH_BODY;
                    end else begin
                        abort_string(ERR_NO_QUOTE);
                    end
                end
            endcase
        end
        if (step_q.size() > 0) step_q[step_q.size()-1].last_of_run = 1'b1;
        foreach (step_q[k]) decoded_q.push_back(step_q[k]);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_state();
            decoded_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                n_out++;
                if (i_out_item.result_kind == KIND_ERROR && i_out_item.error_code <= ERR_UNTERMINATED)
                    err_mask[i_out_item.error_code] = 1'b1;
                if (decoded_q.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("%0t: unexpected result byte=%h kind=%0d code=%0d last=%b",
                                 $time, i_out_item.out_byte, i_out_item.result_kind,
                                 i_out_item.error_code, i_out_item.last_of_run);
                    fails++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_item.out_byte !== want.out_byte ||
                        i_out_item.result_kind !== want.result_kind ||
                        i_out_item.error_code !== want.error_code ||
                        i_out_item.last_of_run !== want.last_of_run) begin
                        if (fails < MAX_REPORTS)
                            $display({"%0t: mismatch expected byte=%h kind=%0d code=%0d last=%b,",
                                      " actual byte=%h kind=%0d code=%0d last=%b"},
                                     $time, want.out_byte, want.result_kind, want.error_code,
                                     want.last_of_run, i_out_item.out_byte,
                                     i_out_item.result_kind, i_out_item.error_code,
                                     i_out_item.last_of_run);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                n_in++;
                decode_byte(i_in_item);
            end
        end
        o_fail_count <= fails;
        o_pending    <= decoded_q.size();
        o_bytes_in   <= n_in;
        o_results    <= n_out;
        o_err_seen   <= err_mask;
    end

endmodule

/* bench/tb_top.sv */
// Testbench top for the JSON string unescaper: clock, reset, byte stream stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int    RANDOM_ITEMS    = 430;
    localparam int    QUIET_FROM      = 370;
    localparam int    HOLD_OFF_AT     = 150;
    localparam int    HOLD_OFF_CYCLES = 80;
    localparam int    DRAIN_CYCLES    = 10;
    localparam string SIMPLE_ESC      = "\"\\/bfnrt";

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    int        fail_count;
    int        pending;
    int        bytes_in;
    int        results;
    bit [8:0]  err_seen;

    t_in_item  text_q[$];
    int        sent_count = 0;
    bit        quiet      = 1'b0;
    bit        hold_done  = 1'b0;

    json_string_unescape_utf8 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    jsu_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_bytes_in   (bytes_in),
        .o_results    (results),
        .o_err_seen   (err_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return "0" + n;
        return ($urandom_range(0, 1) ? "a" : "A") + n - 8'd10;
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [15:0] rand_scalar();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(0, 'h7f));
            1: v = 16'($urandom_range('h80, 'h7ff));
            2: begin
                do v = 16'($urandom_range('h800, 'hffff));
                while (v >= 16'hd800 && v <= 16'hdfff);
            end
            default: begin
                case ($urandom_range(0, 7))
                    0: v = 16'h0000;
                    1: v = 16'h007f;
                    2: v = 16'h0080;
                    3: v = 16'h07ff;
                    4: v = 16'h0800;
                    5: v = 16'hd7ff;
                    6: v = 16'he000;
                    default: v = 16'hffff;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_surrogate(logic [15:0] base);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? base : base + 16'h3ff;
        return base + 16'($urandom_range(0, 'h3ff));
    endfunction

    task automatic put_byte(logic [7:0] b);
        text_q.push_back(t_in_item'{in_byte: b, end_of_text: 1'b0});
    endtask

    task automatic put_end();
        text_q.push_back(t_in_item'{in_byte: 8'($urandom), end_of_text: 1'b1});
    endtask

    task automatic put_hex_digits(logic [15:0] v, int count);
        for (int i = 0; i < count; i++) put_byte(hex_char(v[15-4*i -: 4]));
    endtask

    task automatic put_u(logic [15:0] v);
        put_byte(CH_BACKSLASH);
        put_byte(CH_U);
        put_hex_digits(v, 4);
    endtask

    task automatic put_element();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            do b = 8'($urandom);
            while (b < 8'h20 || b == CH_QUOTE || b == CH_BACKSLASH);
            put_byte(b);
        end else if (r < 7) begin
            put_byte(CH_BACKSLASH);
            put_byte(SIMPLE_ESC[$urandom_range(0, 7)]);
        end else if (r < 9) begin
            put_u(rand_scalar());
        end else begin
            put_u(rand_surrogate(16'hd800));
            put_u(rand_surrogate(16'hdc00));
        end
    endtask

    task automatic put_broken();
        logic [7:0]  b;
        logic [15:0] v;
        int          k;
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 3)) put_element();
        case ($urandom_range(0, 11))
            0: put_byte(8'($urandom_range(0, 'h1f)));
            1: begin
                put_byte(CH_BACKSLASH);
                do b = 8'($urandom);
                while (b == CH_U || b == CH_QUOTE || b == CH_BACKSLASH || b == CH_SLASH ||
                       b == "b" || b == "f" || b == "n" || b == "r" || b == "t");
                put_byte(b);
            end
            2: begin
                put_byte(CH_BACKSLASH);
                put_byte(CH_U);
                put_hex_digits(16'($urandom), $urandom_range(0, 3));
                do b = 8'($urandom); while (is_hex(b));
                put_byte(b);
            end
            3: put_u(rand_surrogate(16'hdc00));
            4: begin
                put_u(rand_surrogate(16'hd800));
                do b = 8'($urandom); while (b == CH_BACKSLASH);
                put_byte(b);
            end
            5: begin
                put_u(rand_surrogate(16'hd800));
                put_byte(CH_BACKSLASH);
                do b = 8'($urandom); while (b == CH_U);
                put_byte(b);
            end
            6: begin
                put_u(rand_surrogate(16'hd800));
                do v = 16'($urandom); while (v >= 16'hdc00 && v <= 16'hdfff);
                put_u(v);
            end
            7: begin
                put_u(rand_surrogate(16'hd800));
                put_byte(CH_BACKSLASH);
                put_byte(CH_U);
                put_hex_digits(16'($urandom), $urandom_range(0, 3));
                do b = 8'($urandom); while (is_hex(b));
                put_byte(b);
            end
            8: put_end();
            9: begin
                put_byte(CH_BACKSLASH);
                put_end();
            end
            10: begin
                put_byte(CH_BACKSLASH);
                put_byte(CH_U);
                put_hex_digits(16'($urandom), $urandom_range(0, 3));
                put_end();
            end
            default: begin
                put_u(rand_surrogate(16'hd800));
                k = $urandom_range(0, 5);
                if (k >= 1) put_byte(CH_BACKSLASH);
                if (k >= 2) put_byte(CH_U);
                if (k > 2) put_hex_digits(16'($urandom), k - 2);
                put_end();
            end
        endcase
    endtask

    task automatic send_text();
        foreach (text_q[k]) begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_item  <= text_q[k];
            do @(posedge i_clk); while (o_in_stall);
            sent_count++;
        end
        text_q.delete();
    endtask

    initial begin
        int rand_start;
        int r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_end();
        put_byte(8'hff);
        put_byte(CH_QUOTE);
        put_byte(8'h20);
        put_byte(8'hff);
        put_byte(CH_BACKSLASH);
        put_byte("t");
        put_byte(CH_QUOTE);
        put_byte(CH_QUOTE);
        put_u(16'hd83d);
        put_u(16'hde00);
        put_byte(8'h1f);
        put_byte(CH_QUOTE);
        put_end();
        send_text();

        rand_start = sent_count;
        while (sent_count - rand_start < RANDOM_ITEMS) begin
            if (sent_count - rand_start >= QUIET_FROM) quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 65) begin
                put_byte(CH_QUOTE);
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom_range(0, 5))
                    put_element();
                put_byte(CH_QUOTE);
            end else if (r < 95) begin
                put_broken();
            end else if ($urandom_range(0, 1)) begin
                put_end();
            end else begin
                do r = $urandom_range(0, 255); while (r == CH_QUOTE);
                put_byte(8'(r));
            end
            send_text();
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input transactions and %0d result transactions.",
                 bytes_in, results);
        $display("Error codes observed (bit n is code n): %b; one output hold-off of %0d cycles.",
                 err_seen, HOLD_OFF_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS json_string_unescape_utf8");
        end else begin
            $display("FAIL json_string_unescape_utf8");
        end
        $finish;
    end

    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!quiet && !hold_done && sent_count >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL json_string_unescape_utf8");
        $finish;
    end

endmodule
